// ===== hdl/tlre_pkg.sv =====
// Shared types, constants and helpers for the trie Levenshtein row engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tlre_pkg;

    // Fixed widths of the configuration and payload fields.
    localparam int WORD_CHARS   = 32;
    localparam int CHAR_IDX_W   = 5;
    localparam int DEPTH_W      = 6;
    localparam int LEN_W        = 6;
    localparam int DIST_W       = 8;
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam logic [DIST_W-1:0] SAT_MAX = 8'hFF;

    // Register indexes, taken from paddr[5:3].
    typedef enum logic [2:0] {
        REG_WORD_LO     = 3'd0,
        REG_WORD_MID_LO = 3'd1,
        REG_WORD_MID_HI = 3'd2,
        REG_WORD_HI     = 3'd3,
        REG_WORD_LENGTH = 3'd4,
        REG_MAX_DIST    = 3'd5,
        REG_MAX_SUFFIX  = 3'd6
    } reg_idx_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [WORD_CHARS-1:0][7:0] word_chars;
        logic [LEN_W-1:0]           word_length;
        logic [DIST_W-1:0]          max_distance;
        logic [DIST_W-1:0]          max_suffix_len;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic col_step;
        logic wr_row;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit;
        logic suffix;
        logic last_col;
        logic out_free;
    } status_t;

    // Saturating increment of a row entry.
    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 8'd1;
    endfunction

endpackage

// ===== hdl/tlre_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on tlre_pkg for the register indexes and the configuration struct.
module tlre_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlre_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlre_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output tlre_pkg::cfg_t                    cfg
);

    logic [63:0]                      word_lo_reg;
    logic [63:0]                      word_mid_lo_reg;
    logic [63:0]                      word_mid_hi_reg;
    logic [63:0]                      word_hi_reg;
    logic [tlre_pkg::LEN_W-1:0]       word_length_reg;
    logic [tlre_pkg::DIST_W-1:0]      max_distance_reg;
    logic [tlre_pkg::DIST_W-1:0]      max_suffix_reg;
    logic                             wr_en;
    logic [2:0]                       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; the access phase of a write transaction updates one register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_lo_reg      <= '0;
            word_mid_lo_reg  <= '0;
            word_mid_hi_reg  <= '0;
            word_hi_reg      <= '0;
            word_length_reg  <= 6'd1;
            max_distance_reg <= '0;
            max_suffix_reg   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tlre_pkg::REG_WORD_LO:     word_lo_reg      <= pwdata;
                tlre_pkg::REG_WORD_MID_LO: word_mid_lo_reg  <= pwdata;
                tlre_pkg::REG_WORD_MID_HI: word_mid_hi_reg  <= pwdata;
                tlre_pkg::REG_WORD_HI:     word_hi_reg      <= pwdata;
                tlre_pkg::REG_WORD_LENGTH: word_length_reg  <= pwdata[5:0];
                tlre_pkg::REG_MAX_DIST:    max_distance_reg <= pwdata[7:0];
                tlre_pkg::REG_MAX_SUFFIX:  max_suffix_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read data follows the address.
    always_comb begin
        unique case (reg_idx)
            tlre_pkg::REG_WORD_LO:     prdata = word_lo_reg;
            tlre_pkg::REG_WORD_MID_LO: prdata = word_mid_lo_reg;
            tlre_pkg::REG_WORD_MID_HI: prdata = word_mid_hi_reg;
            tlre_pkg::REG_WORD_HI:     prdata = word_hi_reg;
            tlre_pkg::REG_WORD_LENGTH: prdata = {58'd0, word_length_reg};
            tlre_pkg::REG_MAX_DIST:    prdata = {56'd0, max_distance_reg};
            tlre_pkg::REG_MAX_SUFFIX:  prdata = {56'd0, max_suffix_reg};
            default:                   prdata = '0;
        endcase
    end

    // Character 0 sits in the low byte of the lowest word register.
    assign cfg.word_chars     = {word_hi_reg, word_mid_hi_reg, word_mid_lo_reg, word_lo_reg};
    assign cfg.word_length    = word_length_reg;
    assign cfg.max_distance   = max_distance_reg;
    assign cfg.max_suffix_len = max_suffix_reg;

endmodule

// ===== hdl/tlre_dp.sv =====
// Datapath: row store memory, column unit that builds one row entry per cycle,
// result logic and output register. Depends on tlre_pkg; driven by tlre_ctrl.
module tlre_dp #(
    parameter int WORD_MAX  = 32,
    parameter int DEPTH_MAX = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tlre_pkg::cfg_t                  cfg,
    input  tlre_pkg::cmd_t                  cmd,
    output tlre_pkg::status_t               status,
    input  logic [tlre_pkg::DEPTH_W-1:0]    s_depth,
    input  logic [7:0]                      s_letter,
    input  logic                            s_has_value,
    input  logic                            s_has_children,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [tlre_pkg::DIST_W-1:0]     m_distance,
    output logic                            m_suffix_match,
    output logic                            m_descend,
    output logic                            m_depth_limit
);

    localparam int AW      = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
    localparam int COL_W   = $clog2(WORD_MAX + 1);
    localparam int ENTRIES = WORD_MAX + 2;
    localparam int MIN_IDX = WORD_MAX + 1;
    localparam logic [8:0] DEPTH_LIM = 9'(DEPTH_MAX);
    localparam logic [tlre_pkg::LEN_W-1:0] WORD_LIM = 6'(WORD_MAX);

    // Each row holds entries 0..WORD_MAX and the row minimum in the top byte.
    logic [ENTRIES-1:0][7:0] row_mem [DEPTH_MAX];
    logic [ENTRIES-1:0][7:0] rd_data_reg;

    logic [tlre_pkg::DEPTH_W-1:0]  depth_reg;
    logic [7:0]                    letter_reg;
    logic                          has_value_reg;
    logic                          has_children_reg;
    logic                          limit_reg;
    logic                          suffix_reg;
    logic                          sfx_ok_reg;
    logic [WORD_MAX:0][7:0]        prev_reg;
    logic [WORD_MAX:0][7:0]        row_reg;
    logic [7:0]                    cur_reg;
    logic [7:0]                    min_reg;
    logic [COL_W-1:0]              col_reg;
    logic [7:0]                    sfx_dist_reg;

    logic                          m_valid_reg;
    logic                          found_reg;
    logic [7:0]                    distance_reg;
    logic                          suffix_match_reg;
    logic                          descend_reg;
    logic                          depth_limit_reg;

    logic [tlre_pkg::LEN_W-1:0]    len;
    logic [tlre_pkg::LEN_W-1:0]    len_m1;
    logic                          in_limit;
    logic                          in_suffix;
    logic                          in_sfx_ok;
    logic                          rd_en;
    logic [tlre_pkg::DEPTH_W-1:0]  rd_row;
    logic [WORD_MAX:0][7:0]        prev_sel;
    logic [7:0]                    first_entry;
    logic [COL_W-1:0]              col_m1;
    logic [tlre_pkg::CHAR_IDX_W-1:0] char_idx;
    logic [7:0]                    ins_cost;
    logic [7:0]                    del_cost;
    logic [7:0]                    rep_cost;
    logic [7:0]                    best;
    logic [ENTRIES-1:0]            wr_be;
    logic [8:0]                    depth_p1;
    logic [8:0]                    sfx_bound;
    logic                          res_found;
    logic [7:0]                    res_dist;
    logic                          res_godeep;
    logic                          res_descend;
    logic                          res_limit;
    logic                          out_free;

    // Effective word length: zero acts as one, large values clamp to the word store.
    always_comb begin
        if (cfg.word_length == '0) begin
            len = 6'd1;
        end else if (cfg.word_length > WORD_LIM) begin
            len = WORD_LIM;
        end else begin
            len = cfg.word_length;
        end
    end
    assign len_m1 = len - 6'd1;

    // Classify the incoming node and pick the row to fetch.
    assign in_limit  = !({3'd0, s_depth} < DEPTH_LIM);
    assign in_suffix = (cfg.max_suffix_len != '0) && (s_depth >= len);
    assign in_sfx_ok = {3'd0, len_m1} < DEPTH_LIM;
    assign rd_row    = in_suffix ? len_m1 : s_depth - 6'd1;
    assign rd_en     = cmd.accept && !in_limit && (in_suffix ? in_sfx_ok : (s_depth != '0));

    // Row store: one registered read port, one write port with byte enables.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= row_mem[AW'(rd_row)];
        end
        if (cmd.wr_row) begin
            for (int e = 0; e < MIN_IDX; e++) begin
                if (wr_be[e]) begin
                    row_mem[AW'(depth_reg)][e] <= row_reg[e[COL_W-1:0]];
                end
            end
            row_mem[AW'(depth_reg)][MIN_IDX] <= min_reg;
        end
    end

    // Only entries 0..len change; the minimum is always rewritten.
    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            wr_be[e] = (e == MIN_IDX) ? 1'b1 : (6'(e) <= len);
        end
    end

    // The row above depth zero is 0, 1, .., n.
    always_comb begin
        for (int i = 0; i <= WORD_MAX; i++) begin
            prev_sel[i] = (depth_reg == '0) ? 8'(i) : rd_data_reg[i];
        end
    end
    assign first_entry = tlre_pkg::sat_inc(prev_sel[0]);

    // Column unit: one entry of the new row per cycle.
    assign col_m1   = col_reg - 1'b1;
    assign char_idx = col_m1[tlre_pkg::CHAR_IDX_W-1:0];
    assign ins_cost = tlre_pkg::sat_inc(cur_reg);
    assign del_cost = tlre_pkg::sat_inc(prev_reg[col_reg]);
    assign rep_cost = (cfg.word_chars[char_idx] != letter_reg)
                    ? tlre_pkg::sat_inc(prev_reg[col_m1]) : prev_reg[col_m1];
    always_comb begin
        best = (ins_cost < del_cost) ? ins_cost : del_cost;
        if (rep_cost < best) begin
            best = rep_cost;
        end
    end

    // Item registers and row working registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            depth_reg        <= s_depth;
            letter_reg       <= s_letter;
            has_value_reg    <= s_has_value;
            has_children_reg <= s_has_children;
            limit_reg        <= in_limit;
            suffix_reg       <= in_suffix;
            sfx_ok_reg       <= in_sfx_ok;
        end
        if (cmd.load) begin
            prev_reg     <= prev_sel;
            row_reg[0]   <= first_entry;
            cur_reg      <= first_entry;
            min_reg      <= first_entry;
            col_reg      <= COL_W'(1);
            sfx_dist_reg <= rd_data_reg[MIN_IDX];
        end
        if (cmd.col_step) begin
            row_reg[col_reg] <= best;
            cur_reg          <= best;
            if (best < min_reg) begin
                min_reg <= best;
            end
            col_reg <= col_reg + 1'b1;
        end
    end

    // Result of the current node; cur_reg holds the last row entry.
    assign depth_p1  = {3'd0, depth_reg} + 9'd1;
    assign sfx_bound = {3'd0, len} + {1'b0, cfg.max_suffix_len};
    always_comb begin
        res_found  = 1'b0;
        res_dist   = '0;
        res_godeep = 1'b0;
        if (suffix_reg) begin
            res_found  = has_value_reg && sfx_ok_reg;
            res_dist   = res_found ? sfx_dist_reg : 8'd0;
            res_godeep = has_children_reg && (depth_p1 < sfx_bound);
        end else if (min_reg <= cfg.max_distance) begin
            res_found  = has_value_reg && (cur_reg <= cfg.max_distance);
            res_dist   = res_found ? cur_reg : 8'd0;
            res_godeep = has_children_reg;
        end
        res_limit   = res_godeep && (depth_p1 >= DEPTH_LIM);
        res_descend = res_godeep && !res_limit;
        if (limit_reg) begin
            res_found   = 1'b0;
            res_dist    = '0;
            res_descend = 1'b0;
            res_limit   = 1'b1;
        end
    end

    // Output register: a finished transaction waits here while the next node starts.
    assign out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            found_reg        <= res_found;
            distance_reg     <= res_dist;
            suffix_match_reg <= res_found && suffix_reg && !limit_reg;
            descend_reg      <= res_descend;
            depth_limit_reg  <= res_limit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = found_reg;
    assign m_distance     = distance_reg;
    assign m_suffix_match = suffix_match_reg;
    assign m_descend      = descend_reg;
    assign m_depth_limit  = depth_limit_reg;

    assign status.limit    = limit_reg;
    assign status.suffix   = suffix_reg;
    assign status.last_col = ({{(8 - COL_W){1'b0}}, col_reg} == {2'd0, len});
    assign status.out_free = out_free;

    // A result must never overwrite one that has not been taken.
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register loaded while holding an untaken result");

    // Rows are written only for nodes that were evaluated.
    a_wr_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_row |-> (!limit_reg && !suffix_reg))
        else $error("row written for a suffix or limit node");

    // The column walk never runs past the word length.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.col_step |-> ({{(8 - COL_W){1'b0}}, col_reg} <= {2'd0, len}))
        else $error("column counter past word length");

    // A result without a match carries no distance and no suffix flag.
    a_nomatch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !found_reg) |-> (distance_reg == '0 && !suffix_match_reg))
        else $error("distance or suffix flag set without a match");

endmodule

// ===== hdl/tlre_ctrl.sv =====
// Controller state machine that sequences fetch, column steps, row write-back
// and result hand-off. Depends on tlre_pkg for the command and status structs.
module tlre_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlre_pkg::status_t   status,
    output tlre_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_COLUMN = 5'b00100,
        S_WRITE  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and per-state commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                if (status.limit || status.suffix) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_COLUMN;
                end
            end
            S_COLUMN: begin
                cmd.col_step = 1'b1;
                if (status.last_col) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.wr_row = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/trie_levenshtein_row_engine.sv =====
// Top level of the trie Levenshtein row engine.
// Depends on tlre_pkg, tlre_regs, tlre_ctrl and tlre_dp.
//
// Feed trie nodes in depth-first order on the s_ channel; each node yields
// exactly one result transaction on the m_ channel. One node is processed at
// a time. A node that builds an edit-distance row goes from acceptance to a
// load state for the registered row-store read, then to the column unit,
// which produces one row entry per cycle for n entries (n is the effective
// word length, 1..WORD_MAX), then to a write-back and a result state. Nodes
// in suffix mode or beyond the depth store go from the load state straight to
// the result state. The output register lets a finished result wait for
// m_ready while the next node is accepted. The row store needs no clearing
// after reset; a walk must reach a depth through its parent before reading
// it. Write the configuration registers only while no node is in flight.
module trie_levenshtein_row_engine #(
    parameter int WORD_MAX  = 32,
    parameter int DEPTH_MAX = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tlre_pkg::DEPTH_W-1:0]      s_depth,
    input  logic [7:0]                        s_letter,
    input  logic                              s_has_value,
    input  logic                              s_has_children,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [tlre_pkg::DIST_W-1:0]       m_distance,
    output logic                              m_suffix_match,
    output logic                              m_descend,
    output logic                              m_depth_limit,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlre_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlre_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    tlre_pkg::cfg_t    cfg;
    tlre_pkg::cmd_t    cmd;
    tlre_pkg::status_t status;

    // Configuration registers.
    tlre_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing.
    tlre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Row store, column unit and output register.
    tlre_dp #(
        .WORD_MAX  (WORD_MAX),
        .DEPTH_MAX (DEPTH_MAX)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_depth        (s_depth),
        .s_letter       (s_letter),
        .s_has_value    (s_has_value),
        .s_has_children (s_has_children),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_distance     (m_distance),
        .m_suffix_match (m_suffix_match),
        .m_descend      (m_descend),
        .m_depth_limit  (m_depth_limit)
    );

endmodule
